// ----- src/rhlb_pkg.sv -----
// shared types and constants for the rgb histogram log bar overlay
`timescale 1ns / 1ps
`default_nettype none
package rhlb_pkg;

  localparam int MANT_BITS = 30;
  localparam int NUM_BINS  = 256;
  localparam int BIN_AW    = 8;

  localparam logic [1:0] REQ_COUNT  = 2'd0;
  localparam logic [1:0] REQ_CLEAR  = 2'd1;
  localparam logic [1:0] REQ_RENDER = 2'd2;
  localparam logic [1:0] REQ_RSVD   = 2'd3;

  localparam logic [1:0] CFG_ENABLE   = 2'd0;
  localparam logic [1:0] CFG_LOG_BASE = 2'd1;
  localparam logic [1:0] CFG_AMP      = 2'd2;

  localparam logic       ENABLE_RST   = 1'b0;
  localparam logic [7:0] LOG_BASE_RST = 8'd110;
  localparam logic [7:0] AMP_RST      = 8'd100;

  localparam logic [9:0] PANEL_LO_A = 10'd12;
  localparam logic [9:0] PANEL_HI_A = 10'd268;
  localparam logic [9:0] PANEL_LO_B = 10'd292;
  localparam logic [9:0] PANEL_HI_B = 10'd548;

  // floor(b * 2^30 / 100) = b * floor(2^28 / 25) + floor(6 b / 25)
  localparam logic [7:0]  BASE_MIN       = 8'd101;
  localparam logic [31:0] BASE_MUL       = 32'd10737418;
  localparam logic [23:0] BASE_FIX_MUL   = 24'd7866;
  localparam int          BASE_FIX_SHIFT = 15;
  localparam logic [6:0]  HUNDRED        = 7'd100;

  localparam logic [7:0] PIX_ON  = 8'd255;
  localparam logic [7:0] PIX_OFF = 8'd0;

  typedef struct packed {
    logic accept;
    logic cnt_wr;
    logic clr_wr;
    logic base_start;
    logic lb_cap;
    logic d_mul;
    logic ch_start;
    logic lc_cap;
    logic ch_mul;
    logic ch_cmp;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic req_count;
    logic req_clear;
    logic req_render;
    logic clr_last;
    logic log_done;
    logic mask_empty;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ----- src/rgb_histogram_log_bar_overlay.sv -----
// top level: rgb histogram with log-scaled bar overlay rendering
//
//  channel   direction  handshake                  payload
//  request   in         in_valid_i / in_stall_o     req_type, pix_blue/green/red, row, col
//  result    out        out_valid_o / out_stall_i   out_blue, out_green, out_red
//  config    in         cfg_we_i                    cfg_idx_i, cfg_wdata_i
//
// count request: bin read on accept, then saturating write; clear: zeroes every bin in turn
// render: base log, then one log per panel channel (all three in the top-left panel,
//   one in each other panel, none outside) on the shared square-per-bit log2 unit
// bins are zeroed by a clearing pass after reset and on clear, input stalled meanwhile
// a finished result waits in the output register; only a render finishing behind it stalls
`timescale 1ns / 1ps
`default_nettype none
module rgb_histogram_log_bar_overlay #(
  parameter int COUNT_BITS    = 32,
  parameter int LOG_FRAC_BITS = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [7:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] req_type_i,
  input  wire logic [7:0] pix_blue_i,
  input  wire logic [7:0] pix_green_i,
  input  wire logic [7:0] pix_red_i,
  input  wire logic [9:0] row_i,
  input  wire logic [9:0] col_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_blue_o,
  output logic [7:0]      out_green_o,
  output logic [7:0]      out_red_o
);

  rhlb_pkg::cmd_t cmd;
  rhlb_pkg::sts_t sts;

  rhlb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rhlb_datapath #(
    .COUNT_BITS    (COUNT_BITS),
    .LOG_FRAC_BITS (LOG_FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_type_i  (req_type_i),
    .pix_blue_i  (pix_blue_i),
    .pix_green_i (pix_green_i),
    .pix_red_i   (pix_red_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_blue_o  (out_blue_o),
    .out_green_o (out_green_o),
    .out_red_o   (out_red_o)
  );

endmodule
`default_nettype wire

// ----- src/rhlb_log2.sv -----
// iterative fixed-point log2 unit: normalise a count (a base mantissa skips this), then one fraction bit per square
`timescale 1ns / 1ps
`default_nettype none
module rhlb_log2 #(
  parameter int COUNT_BITS    = 32,
  parameter int LOG_FRAC_BITS = 16
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          rst_ni,
  input  wire logic                                          start_i,
  input  wire logic                                          is_base_i,
  input  wire logic [COUNT_BITS:0]                           x_i,
  input  wire logic [31:0]                                   bmant_i,
  output logic                                               done_o,
  output logic [$clog2(COUNT_BITS+1)+LOG_FRAC_BITS-1:0]      lg_o
);

  localparam int W   = COUNT_BITS + 1;
  localparam int EW  = $clog2(W);
  localparam int F   = LOG_FRAC_BITS;
  localparam int SK  = $clog2(W);
  localparam int KW  = $clog2(SK);
  localparam int FCW = $clog2(F);
  localparam int MW  = rhlb_pkg::MANT_BITS + 1;
  localparam int EXT = (W > MW) ? W : MW;
  localparam int PW  = 2 * MW;

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_NORM = 2'd1;
  localparam logic [1:0] P_SQ   = 2'd2;
  localparam logic [1:0] P_FIX  = 2'd3;

  logic [1:0]     ph_q, ph_d;
  logic           done_q, done_d;
  logic [W-1:0]   nrm_q;
  logic [EW-1:0]  e_q;
  logic [KW-1:0]  k_q;
  logic [FCW-1:0] fc_q;
  logic [MW-1:0]  mant_q;
  logic [PW-1:0]  prod_q;
  logic [F-1:0]   frac_q;

  logic [EW:0]    sh;
  logic           top_zero;
  logic [W-1:0]   nrm_nx;
  logic [EW-1:0]  e_nx;
  logic [EXT-1:0] ext;
  logic [MW-1:0]  mant_nrm;
  logic [MW:0]    sq;

  always_comb begin
    sh       = (EW+1)'(1) << k_q;
    top_zero = (nrm_q >> ((EW+1)'(W) - sh)) == '0;
    nrm_nx   = top_zero ? (nrm_q << sh) : nrm_q;
    e_nx     = top_zero ? (e_q - sh[EW-1:0]) : e_q;
    ext      = EXT'(nrm_nx) << (EXT - W);
    mant_nrm = ext[EXT-1 -: MW];
    sq       = prod_q[PW-1 -: MW+1];
  end

  always_comb begin
    ph_d   = ph_q;
    done_d = 1'b0;
    case (ph_q)
      P_IDLE: begin
        if (start_i) begin
          ph_d = is_base_i ? P_SQ : P_NORM;
        end
      end
      P_NORM: begin
        if (k_q == '0) begin
          ph_d = P_SQ;
        end
      end
      P_SQ: ph_d = P_FIX;
      P_FIX: begin
        if (fc_q == FCW'(F - 1)) begin
          ph_d   = P_IDLE;
          done_d = 1'b1;
        end else begin
          ph_d = P_SQ;
        end
      end
      default: ph_d = P_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= P_IDLE;
      done_q <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (ph_q)
      P_IDLE: begin
        if (start_i) begin
          fc_q <= '0;
          k_q  <= KW'(SK - 1);
          if (is_base_i) begin
            e_q    <= EW'(bmant_i[31]);
            mant_q <= bmant_i[31] ? bmant_i[31:1] : bmant_i[30:0];
          end else begin
            nrm_q <= x_i;
            e_q   <= EW'(W - 1);
          end
        end
      end
      P_NORM: begin
        nrm_q <= nrm_nx;
        e_q   <= e_nx;
        k_q   <= k_q - 1'b1;
        if (k_q == '0) begin
          mant_q <= mant_nrm;
        end
      end
      P_SQ: prod_q <= PW'(mant_q) * PW'(mant_q);
      P_FIX: begin
        // square reached two: halve and emit a one; else emit a zero
        frac_q <= {frac_q[F-2:0], sq[MW]};
        mant_q <= sq[MW] ? sq[MW:1] : sq[MW-1:0];
        fc_q   <= fc_q + 1'b1;
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign lg_o   = {e_q, frac_q};

endmodule
`default_nettype wire

// ----- src/rhlb_datapath.sv -----
// datapath: config registers, bin memories, log unit, bar compare, result register
`timescale 1ns / 1ps
`default_nettype none
module rhlb_datapath #(
  parameter int COUNT_BITS    = 32,
  parameter int LOG_FRAC_BITS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire rhlb_pkg::cmd_t   cmd_i,
  output rhlb_pkg::sts_t        sts_o,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_idx_i,
  input  wire logic [7:0]       cfg_wdata_i,
  input  wire logic [1:0]       req_type_i,
  input  wire logic [7:0]       pix_blue_i,
  input  wire logic [7:0]       pix_green_i,
  input  wire logic [7:0]       pix_red_i,
  input  wire logic [9:0]       row_i,
  input  wire logic [9:0]       col_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [7:0]            out_blue_o,
  output logic [7:0]            out_green_o,
  output logic [7:0]            out_red_o
);

  localparam int W  = COUNT_BITS + 1;
  localparam int EW = $clog2(W);
  localparam int LW = EW + LOG_FRAC_BITS;
  localparam int AW = rhlb_pkg::BIN_AW;
  localparam int NB = rhlb_pkg::NUM_BINS;

  logic       enable_q;
  logic [7:0] base_q, amp_q;

  logic [COUNT_BITS-1:0] mem_b [NB];
  logic [COUNT_BITS-1:0] mem_g [NB];
  logic [COUNT_BITS-1:0] mem_r [NB];
  logic [AW-1:0]         clr_adr_q;
  logic [COUNT_BITS-1:0] rd_b_q, rd_g_q, rd_r_q;
  logic [AW-1:0]         adr_b_q, adr_g_q, adr_r_q;
  logic [AW-1:0]         adr_b_d, adr_g_d, adr_r_d;
  logic [COUNT_BITS-1:0] val_b, val_g, val_r;

  logic       top, bot, left, right;
  logic [9:0] kfull, bottom, dfull;
  logic [2:0] mask_d, mask_q;
  logic [8:0] d_q;
  logic [2:0] lit_q;
  logic [1:0] ch_q, ch_d;
  logic       outv_q;
  logic [7:0] ob_q, og_q, or_q;

  logic [7:0]         b_sel;
  logic [23:0]        fix_prod;
  logic [31:0]        bmant;
  logic [COUNT_BITS-1:0] ch_cnt;
  logic [W-1:0]       x;
  logic               log_done;
  logic [LW-1:0]      lg;
  logic [LW-1:0]      lb_q, lc_q;
  logic [LW+6:0]      dd_q;
  logic [LW+7:0]      n_q;
  logic [LW+15:0]     p_q;
  logic               is_render;

  assign is_render = enable_q && (req_type_i == rhlb_pkg::REQ_RENDER);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= rhlb_pkg::ENABLE_RST;
      base_q   <= rhlb_pkg::LOG_BASE_RST;
      amp_q    <= rhlb_pkg::AMP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rhlb_pkg::CFG_ENABLE:   enable_q <= cfg_wdata_i[0];
        rhlb_pkg::CFG_LOG_BASE: base_q   <= cfg_wdata_i;
        rhlb_pkg::CFG_AMP:      amp_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // panel decode
  always_comb begin
    top    = (row_i >= rhlb_pkg::PANEL_LO_A) && (row_i < rhlb_pkg::PANEL_HI_A);
    bot    = (row_i >= rhlb_pkg::PANEL_LO_B) && (row_i < rhlb_pkg::PANEL_HI_B);
    left   = (col_i >= rhlb_pkg::PANEL_LO_A) && (col_i < rhlb_pkg::PANEL_HI_A);
    right  = (col_i >= rhlb_pkg::PANEL_LO_B) && (col_i < rhlb_pkg::PANEL_HI_B);
    kfull  = left ? (col_i - rhlb_pkg::PANEL_LO_A) : (col_i - rhlb_pkg::PANEL_LO_B);
    bottom = top ? rhlb_pkg::PANEL_HI_A : rhlb_pkg::PANEL_HI_B;
    dfull  = bottom - row_i;
    // bit 0 blue, bit 1 green, bit 2 red
    mask_d = 3'b000;
    if (top && left) begin
      mask_d = 3'b111;
    end else if (top && right) begin
      mask_d = 3'b100;
    end else if (bot && left) begin
      mask_d = 3'b010;
    end else if (bot && right) begin
      mask_d = 3'b001;
    end
    if (is_render) begin
      adr_b_d = kfull[AW-1:0];
      adr_g_d = kfull[AW-1:0];
      adr_r_d = kfull[AW-1:0];
    end else begin
      adr_b_d = pix_blue_i;
      adr_g_d = pix_green_i;
      adr_r_d = pix_red_i;
    end
  end

  assign val_b = rd_b_q;
  assign val_g = rd_g_q;
  assign val_r = rd_r_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cnt_wr) begin
      mem_b[adr_b_q] <= (val_b == '1) ? val_b : val_b + 1'b1;
      mem_g[adr_g_q] <= (val_g == '1) ? val_g : val_g + 1'b1;
      mem_r[adr_r_q] <= (val_r == '1) ? val_r : val_r + 1'b1;
    end else if (cmd_i.clr_wr) begin
      mem_b[clr_adr_q] <= '0;
      mem_g[clr_adr_q] <= '0;
      mem_r[clr_adr_q] <= '0;
    end
    if (cmd_i.accept) begin
      rd_b_q <= mem_b[adr_b_d];
      rd_g_q <= mem_g[adr_g_d];
      rd_r_q <= mem_r[adr_r_d];
    end
  end

  // clearing pass address, one entry of each memory per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_adr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_adr_q <= clr_adr_q + 1'b1;
    end
  end

  // lowest pending channel
  always_comb begin
    if (mask_q[0]) begin
      ch_d = 2'd0;
    end else if (mask_q[1]) begin
      ch_d = 2'd1;
    end else begin
      ch_d = 2'd2;
    end
    case (ch_d)
      2'd0:    ch_cnt = val_b;
      2'd1:    ch_cnt = val_g;
      default: ch_cnt = val_r;
    endcase
    x        = {1'b0, ch_cnt} + 1'b1;
    b_sel    = (base_q < rhlb_pkg::BASE_MIN) ? rhlb_pkg::BASE_MIN : base_q;
    fix_prod = 24'(b_sel) * rhlb_pkg::BASE_FIX_MUL;
    bmant    = 32'(b_sel) * rhlb_pkg::BASE_MUL
             + 32'(fix_prod >> rhlb_pkg::BASE_FIX_SHIFT);
  end

  rhlb_log2 #(
    .COUNT_BITS    (COUNT_BITS),
    .LOG_FRAC_BITS (LOG_FRAC_BITS)
  ) u_log2 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.base_start | cmd_i.ch_start),
    .is_base_i (cmd_i.base_start),
    .x_i       (x),
    .bmant_i   (bmant),
    .done_o    (log_done),
    .lg_o      (lg)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      adr_b_q <= adr_b_d;
      adr_g_q <= adr_g_d;
      adr_r_q <= adr_r_d;
      d_q     <= dfull[8:0];
    end
    if (cmd_i.lb_cap) begin
      lb_q <= (lg == '0) ? LW'(1) : lg;
    end
    if (cmd_i.d_mul) begin
      dd_q <= (LW+7)'(lb_q) * (LW+7)'(rhlb_pkg::HUNDRED);
    end
    if (cmd_i.ch_start) begin
      ch_q <= ch_d;
    end
    if (cmd_i.lc_cap) begin
      lc_q <= lg;
    end
    if (cmd_i.ch_mul) begin
      n_q <= (LW+8)'(lc_q) * (LW+8)'(amp_q);
      p_q <= (LW+16)'(d_q) * (LW+16)'(dd_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      lit_q  <= '0;
    end else if (cmd_i.accept) begin
      mask_q <= is_render ? mask_d : 3'b000;
      lit_q  <= '0;
    end else if (cmd_i.ch_cmp) begin
      // lit when floor(n / p_unit) reaches the distance to the panel bottom
      mask_q[ch_q] <= 1'b0;
      lit_q[ch_q]  <= ((LW+16)'(n_q) >= p_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outv_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      outv_q <= 1'b1;
    end else if (!out_stall_i) begin
      outv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      ob_q <= lit_q[0] ? rhlb_pkg::PIX_ON : rhlb_pkg::PIX_OFF;
      og_q <= lit_q[1] ? rhlb_pkg::PIX_ON : rhlb_pkg::PIX_OFF;
      or_q <= lit_q[2] ? rhlb_pkg::PIX_ON : rhlb_pkg::PIX_OFF;
    end
  end

  assign out_valid_o = outv_q;
  assign out_blue_o  = ob_q;
  assign out_green_o = og_q;
  assign out_red_o   = or_q;

  always_comb begin
    sts_o.req_count  = enable_q && (req_type_i == rhlb_pkg::REQ_COUNT);
    sts_o.req_clear  = enable_q && (req_type_i == rhlb_pkg::REQ_CLEAR);
    sts_o.req_render = is_render;
    sts_o.clr_last   = (clr_adr_q == '1);
    sts_o.log_done   = log_done;
    sts_o.mask_empty = (mask_q == 3'b000);
    sts_o.out_free   = !outv_q || !out_stall_i;
  end

endmodule
`default_nettype wire

// ----- src/rhlb_ctrl.sv -----
// request sequencer for count, clear and render
`timescale 1ns / 1ps
`default_nettype none
module rhlb_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire rhlb_pkg::sts_t sts_i,
  output rhlb_pkg::cmd_t      cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CWR    = 4'd1;
  localparam logic [3:0] S_BSTART = 4'd2;
  localparam logic [3:0] S_BRUN   = 4'd3;
  localparam logic [3:0] S_DMUL   = 4'd4;
  localparam logic [3:0] S_CSEL   = 4'd5;
  localparam logic [3:0] S_CRUN   = 4'd6;
  localparam logic [3:0] S_CMUL   = 4'd7;
  localparam logic [3:0] S_CCMP   = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;
  localparam logic [3:0] S_CLR    = 4'd10;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.req_count) begin
            state_d = S_CWR;
          end else if (sts_i.req_clear) begin
            state_d = S_CLR;
          end else if (sts_i.req_render) begin
            state_d = S_BSTART;
          end
        end
      end
      S_CWR: begin
        cmd_o.cnt_wr = 1'b1;
        state_d      = S_IDLE;
      end
      S_CLR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_BSTART: begin
        cmd_o.base_start = 1'b1;
        state_d          = S_BRUN;
      end
      S_BRUN: begin
        if (sts_i.log_done) begin
          cmd_o.lb_cap = 1'b1;
          state_d      = S_DMUL;
        end
      end
      S_DMUL: begin
        cmd_o.d_mul = 1'b1;
        state_d     = S_CSEL;
      end
      S_CSEL: begin
        if (sts_i.mask_empty) begin
          state_d = S_OUT;
        end else begin
          cmd_o.ch_start = 1'b1;
          state_d        = S_CRUN;
        end
      end
      S_CRUN: begin
        if (sts_i.log_done) begin
          cmd_o.lc_cap = 1'b1;
          state_d      = S_CMUL;
        end
      end
      S_CMUL: begin
        cmd_o.ch_mul = 1'b1;
        state_d      = S_CCMP;
      end
      S_CCMP: begin
        cmd_o.ch_cmp = 1'b1;
        state_d      = S_CSEL;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // bins are zeroed by a clearing pass straight after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

`ifndef NO_ASSERTIONS
  a_done_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.log_done |-> (state_q == S_BRUN || state_q == S_CRUN))
    else $error("log unit finished while sequencer not waiting");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result loaded over an unread result");

  a_base_not_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_BSTART |=> !sts_i.log_done)
    else $error("log unit reported done right after start");

  a_cmp_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CCMP |=> state_q == S_CSEL)
    else $error("channel compare not followed by channel select");
`endif

endmodule
`default_nettype wire

// ----- tb/tb_rgb_histogram_log_bar_overlay.sv -----
// testbench for the rgb histogram log bar overlay: directed and random requests, self-checking
`timescale 1ns / 1ps
module tb_rgb_histogram_log_bar_overlay;

  localparam int COUNT_W   = 32;
  localparam int FRAC_W    = 16;
  localparam int MANT_W    = 30;
  localparam int SETTLE    = 400;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_idx = rhlb_pkg::CFG_ENABLE;
  logic [7:0] cfg_wdata = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] req_type = rhlb_pkg::REQ_COUNT;
  logic [7:0] pix_blue = '0, pix_green = '0, pix_red = '0;
  logic [9:0] row = '0, col = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_blue, out_green, out_red;

  rgb_histogram_log_bar_overlay #(.COUNT_BITS(COUNT_W), .LOG_FRAC_BITS(FRAC_W)) i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .req_type_i(req_type), .pix_blue_i(pix_blue), .pix_green_i(pix_green),
    .pix_red_i(pix_red), .row_i(row), .col_i(col),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_blue_o(out_blue), .out_green_o(out_green), .out_red_o(out_red)
  );

  // model state
  logic [63:0] blue_hist [rhlb_pkg::NUM_BINS];
  logic [63:0] green_hist[rhlb_pkg::NUM_BINS];
  logic [63:0] red_hist  [rhlb_pkg::NUM_BINS];
  logic        en_q;
  logic [7:0]  base_q;
  logic [7:0]  amp_q;

  pixel_t pending_pixels[$];
  int     errors = 0;
  int     gap_pct = 0;
  int     stall_pct = 0;
  int     hold_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  // receiver back-pressure, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    pixel_t exp_px;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        $error("result with nothing expected: %0d %0d %0d", out_blue, out_green, out_red);
        errors++;
      end else begin
        exp_px = pending_pixels.pop_front();
        if (out_blue !== exp_px.blue) begin
          $error("out_blue expected %0d got %0d", exp_px.blue, out_blue);
          errors++;
        end
        if (out_green !== exp_px.green) begin
          $error("out_green expected %0d got %0d", exp_px.green, out_green);
          errors++;
        end
        if (out_red !== exp_px.red) begin
          $error("out_red expected %0d got %0d", exp_px.red, out_red);
          errors++;
        end
      end
    end
  end

  // fraction bits by repeated squaring of a q30 mantissa
  function automatic logic [63:0] log2_fixed(logic [63:0] ipart, logic [63:0] mant);
    logic [63:0] frac;
    frac = '0;
    for (int i = 0; i < FRAC_W; i++) begin
      mant = (mant * mant) >> MANT_W;
      frac = frac << 1;
      if (mant >= (64'd2 << MANT_W)) begin
        mant = mant >> 1;
        frac[0] = 1'b1;
      end
    end
    return (ipart << FRAC_W) | frac;
  endfunction

  function automatic logic [63:0] log2_count(logic [63:0] x);
    logic [63:0] e, mant;
    e = 0;
    while (e < 63 && (x >> (e + 1)) != 0) e++;
    if (e >= MANT_W) mant = x >> (e - MANT_W);
    else mant = x << (MANT_W - e);
    return log2_fixed(e, mant);
  endfunction

  function automatic logic [63:0] bar_height(logic [63:0] count);
    logic [63:0] b, mant, ip, lb, lc, h;
    b = (base_q < rhlb_pkg::BASE_MIN) ? 64'(rhlb_pkg::BASE_MIN) : 64'(base_q);
    mant = (b << MANT_W) / 100;
    ip = 0;
    if (mant >= (64'd2 << MANT_W)) begin
      mant = mant >> 1;
      ip = 1;
    end
    lb = log2_fixed(ip, mant);
    if (lb == 0) lb = 1;
    lc = log2_count(count + 1);
    h = (lc * 64'(amp_q)) / (lb * 100);
    return (h > 256) ? 64'd256 : h;
  endfunction

  function automatic logic [7:0] bar_pixel(logic [63:0] count, logic [9:0] r,
                                           logic [9:0] bottom);
    logic [63:0] h;
    h = bar_height(count);
    return (64'(r) + h >= 64'(bottom) && r < bottom) ? rhlb_pkg::PIX_ON : rhlb_pkg::PIX_OFF;
  endfunction

  function automatic logic [63:0] count_next(logic [63:0] bin);
    return (bin < ((64'd1 << COUNT_W) - 1)) ? bin + 1 : bin;
  endfunction

  // apply one accepted request to the model, queueing the expected pixel of a render
  function automatic void model_request(logic [1:0] kind, logic [7:0] b, logic [7:0] g,
                                        logic [7:0] r, logic [9:0] y, logic [9:0] x);
    pixel_t px;
    logic top, bot, left, right;
    logic [7:0] k;
    if (!en_q) return;
    if (kind == rhlb_pkg::REQ_COUNT) begin
      blue_hist[b] = count_next(blue_hist[b]);
      green_hist[g] = count_next(green_hist[g]);
      red_hist[r] = count_next(red_hist[r]);
    end else if (kind == rhlb_pkg::REQ_CLEAR) begin
      foreach (blue_hist[i]) begin
        blue_hist[i] = 0;
        green_hist[i] = 0;
        red_hist[i] = 0;
      end
    end else if (kind == rhlb_pkg::REQ_RENDER) begin
      px = '{rhlb_pkg::PIX_OFF, rhlb_pkg::PIX_OFF, rhlb_pkg::PIX_OFF};
      top = y >= rhlb_pkg::PANEL_LO_A && y < rhlb_pkg::PANEL_HI_A;
      bot = y >= rhlb_pkg::PANEL_LO_B && y < rhlb_pkg::PANEL_HI_B;
      left = x >= rhlb_pkg::PANEL_LO_A && x < rhlb_pkg::PANEL_HI_A;
      right = x >= rhlb_pkg::PANEL_LO_B && x < rhlb_pkg::PANEL_HI_B;
      if (top && left) begin
        k = 8'(x - rhlb_pkg::PANEL_LO_A);
        px.blue = bar_pixel(blue_hist[k], y, rhlb_pkg::PANEL_HI_A);
        px.green = bar_pixel(green_hist[k], y, rhlb_pkg::PANEL_HI_A);
        px.red = bar_pixel(red_hist[k], y, rhlb_pkg::PANEL_HI_A);
      end else if (top && right) begin
        k = 8'(x - rhlb_pkg::PANEL_LO_B);
        px.red = bar_pixel(red_hist[k], y, rhlb_pkg::PANEL_HI_A);
      end else if (bot && left) begin
        k = 8'(x - rhlb_pkg::PANEL_LO_A);
        px.green = bar_pixel(green_hist[k], y, rhlb_pkg::PANEL_HI_B);
      end else if (bot && right) begin
        k = 8'(x - rhlb_pkg::PANEL_LO_B);
        px.blue = bar_pixel(blue_hist[k], y, rhlb_pkg::PANEL_HI_B);
      end
      pending_pixels.push_back(px);
    end
  endfunction

  task automatic send_req(logic [1:0] kind, logic [7:0] b, logic [7:0] g, logic [7:0] r,
                          logic [9:0] y, logic [9:0] x);
    in_valid <= 1'b1;
    req_type <= kind;
    pix_blue <= b;
    pix_green <= g;
    pix_red <= r;
    row <= y;
    col <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model_request(kind, b, g, r, y, x);
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_pixels.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rhlb_pkg::CFG_ENABLE:   en_q = value[0];
      rhlb_pkg::CFG_LOG_BASE: base_q = value;
      rhlb_pkg::CFG_AMP:      amp_q = value;
      default: ;
    endcase
  endtask

  task automatic send_render(logic [9:0] y, logic [9:0] x);
    send_req(rhlb_pkg::REQ_RENDER, 8'($urandom), 8'($urandom), 8'($urandom), y, x);
  endtask

  task automatic test_directed();
    // disabled: nothing comes back
    send_render(10'd260, 10'd20);
    send_req(rhlb_pkg::REQ_COUNT, 8'd0, 8'd0, 8'd0, 10'd0, 10'd0);
    drain();
    write_reg(rhlb_pkg::CFG_ENABLE, 8'd1);
    repeat (3) send_req(rhlb_pkg::REQ_COUNT, 8'd0, 8'd255, 8'd0, 10'd1023, 10'd1023);
    send_req(rhlb_pkg::REQ_COUNT, 8'd255, 8'd0, 8'd255, 10'd0, 10'd0);
    send_req(rhlb_pkg::REQ_RSVD, 8'd255, 8'd255, 8'd255, 10'd300, 10'd300);
    send_render(10'd267, 10'd12);
    send_render(10'd267, 10'd267);
    send_render(10'd12, 10'd292);
    send_render(10'd547, 10'd12);
    send_render(10'd547, 10'd547);
    send_render(10'd547, 10'd548);
    send_render(10'd268, 10'd20);
    send_render(10'd1023, 10'd1023);
    send_render(10'd0, 10'd0);
    drain();
    write_reg(rhlb_pkg::CFG_LOG_BASE, 8'd0);
    write_reg(rhlb_pkg::CFG_AMP, 8'd255);
    send_render(10'd267, 10'd12);
    send_render(10'd30, 10'd12);
    drain();
    write_reg(rhlb_pkg::CFG_LOG_BASE, 8'd255);
    write_reg(rhlb_pkg::CFG_AMP, 8'd0);
    send_render(10'd267, 10'd12);
    send_req(rhlb_pkg::REQ_CLEAR, 8'd0, 8'd0, 8'd0, 10'd0, 10'd0);
    send_render(10'd547, 10'd12);
    drain();
  endtask

  // mostly counts on a narrow bin window and renders near the panel bottoms
  task automatic test_random(int n, int gp, int sp);
    int roll, lo;
    logic [9:0] y, x;
    gap_pct = gp;
    stall_pct = sp;
    lo = $urandom_range(0, 240);
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < 50) begin
        if ($urandom_range(3) == 0)
          send_req(rhlb_pkg::REQ_COUNT, 8'($urandom), 8'($urandom), 8'($urandom),
                   10'($urandom), 10'($urandom));
        else
          send_req(rhlb_pkg::REQ_COUNT, 8'($urandom_range(lo, lo + 15)),
                   8'($urandom_range(lo, lo + 15)), 8'($urandom_range(lo, lo + 15)),
                   10'($urandom), 10'($urandom));
      end else if (roll < 51) begin
        send_req(rhlb_pkg::REQ_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom),
                 10'($urandom), 10'($urandom));
      end else if (roll < 53) begin
        send_req(rhlb_pkg::REQ_RSVD, 8'($urandom), 8'($urandom), 8'($urandom),
                 10'($urandom), 10'($urandom));
      end else if (roll < 90) begin
        y = ($urandom_range(1)) ? 10'(rhlb_pkg::PANEL_HI_A - $urandom_range(1, 40))
                                : 10'(rhlb_pkg::PANEL_HI_B - $urandom_range(1, 40));
        x = ($urandom_range(1)) ? 10'(rhlb_pkg::PANEL_LO_A + lo + $urandom_range(0, 15))
                                : 10'(rhlb_pkg::PANEL_LO_B + lo + $urandom_range(0, 15));
        send_render(y, x);
      end else begin
        send_render(10'($urandom), 10'($urandom));
      end
    end
    drain();
  endtask

  task automatic test_backpressure();
    gap_pct = 0;
    stall_pct = 0;
    hold_left = 600;
    for (int i = 0; i < 20; i++) begin
      send_render(10'(rhlb_pkg::PANEL_HI_A - $urandom_range(1, 20)),
                  10'(rhlb_pkg::PANEL_LO_A + $urandom_range(0, 255)));
      send_req(rhlb_pkg::REQ_COUNT, 8'($urandom), 8'($urandom), 8'($urandom),
               10'($urandom), 10'($urandom));
    end
    // pause until everything is back, then carry on
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_pixels.size() == 0);
    for (int i = 0; i < 10; i++)
      send_render(10'(rhlb_pkg::PANEL_HI_B - $urandom_range(1, 20)),
                  10'(rhlb_pkg::PANEL_LO_B + $urandom_range(0, 255)));
    drain();
  endtask

  initial begin
    foreach (blue_hist[i]) begin
      blue_hist[i] = 0;
      green_hist[i] = 0;
      red_hist[i] = 0;
    end
    en_q = rhlb_pkg::ENABLE_RST;
    base_q = rhlb_pkg::LOG_BASE_RST;
    amp_q = rhlb_pkg::AMP_RST;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(250, 0, 0);
    write_reg(rhlb_pkg::CFG_LOG_BASE, 8'd101);
    write_reg(rhlb_pkg::CFG_AMP, 8'd200);
    test_random(250, 83, 0);
    write_reg(rhlb_pkg::CFG_LOG_BASE, 8'd200);
    write_reg(rhlb_pkg::CFG_AMP, 8'd20);
    test_random(250, 0, 83);
    write_reg(rhlb_pkg::CFG_LOG_BASE, 8'($urandom_range(101, 200)));
    write_reg(rhlb_pkg::CFG_AMP, 8'($urandom_range(20, 200)));
    test_random(200, 14, 14);
    test_backpressure();
    write_reg(rhlb_pkg::CFG_ENABLE, 8'd0);
    test_random(20, 14, 14);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
